// ===== rtl/smeq_pkg.sv =====
// Shared types, command codes, state encoding and gain table for the equalizer.
package smeq_pkg;

	// command codes
	localparam logic [1:0] CMD_SAMPLE = 2'd0;
	localparam logic [1:0] CMD_COEF   = 2'd1;
	localparam logic [1:0] CMD_GAIN   = 2'd2;

	typedef struct packed {
		logic [1:0]         cmd;
		logic signed [23:0] right_sample;
		logic signed [23:0] left_sample;
		logic [1:0]         band;
		logic               section;
		logic               coef_kind;
		logic [1:0]         tap;
		logic signed [31:0] coef_value;
		logic signed [7:0]  gain_tenths_db;
	} item_t;

	typedef struct packed {
		logic signed [23:0] right_out;
		logic signed [23:0] left_out;
	} result_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOAD,
		ST_ISSUE,
		ST_DRAIN,
		ST_WB,
		ST_GMUL,
		ST_GACC,
		ST_DONE
	} state_t;

	localparam int          GAIN_MAX   = 120;
	localparam int          GAIN_STEPS = 2 * GAIN_MAX + 1;
	localparam int          GAIN_W     = 18;
	localparam logic [17:0] UNITY_GAIN = 18'd65536;
	localparam logic [63:0] STEP_UP    = 64'd1086175168;
	localparam logic [63:0] STEP_DOWN  = 64'd1061450803;

	localparam int ACC_W = 40;
	localparam int SUM_W = 56;

	typedef logic [GAIN_W-1:0] gain_tab_t [GAIN_STEPS];

	// 10^(d/200) in Q2.16, built by repeated Q2.30 steps at elaboration
	function automatic gain_tab_t build_gain_tab();
		gain_tab_t   tab;
		logic [63:0] g;
		logic [63:0] step;
		int          n;
		for (int d = -GAIN_MAX; d <= GAIN_MAX; d++) begin
			g    = 64'd1 << 30;
			step = (d < 0) ? STEP_DOWN : STEP_UP;
			n    = (d < 0) ? -d : d;
			for (int i = 0; i < n; i++)
				g = (g * step + (64'd1 << 29)) >> 30;
			tab[d + GAIN_MAX] = GAIN_W'((g + (64'd1 << 13)) >> 14);
		end
		return tab;
	endfunction

	localparam gain_tab_t GAIN_TAB = build_gain_tab();

endpackage

// ===== rtl/smeq_stream_if.sv =====
// Valid/ready stream channel carrying one payload beat.
interface smeq_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/smeq_ram.sv =====
// Generic simple dual-port RAM with registered read.
module smeq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/stereo_multiband_iir_equalizer.sv =====
// Stereo multiband direct-form-I IIR equalizer with a shared multiplier.
//
// Channels: "items" takes command beats (sample, coefficient write, gain
// write); "results" gives one stereo beat per sample command. Coefficient and
// gain writes take effect at once and return nothing.
// cfg_we/cfg_wdata set the cascade band.
// All filter histories and coefficients sit in two RAMs with registered read;
// one 32x32 multiplier and one accumulator step through every tap in turn.
// Per band and channel a sample takes the tap reads, a drain of the multiplier
// pipe, a write-back and the gain multiply and accumulate steps; a selected
// cascade band runs its taps and write-back once more for its second section.
// No further beat is taken while a sample is being computed.
// After reset a clearing pass zeroes both RAMs, during which no beat is taken.
// If the receiver stalls, the result waits in the output register; further
// beats are still taken and the next sample is computed, but it then holds
// in its final step, taking nothing, until the register is free.
module stereo_multiband_iir_equalizer #(
	parameter int FILTER_ORDER = 2,
	parameter int BAND_COUNT   = 4
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [2:0]              cfg_wdata,
	smeq_stream_if.sink             items,
	smeq_stream_if.source           results
);
	import smeq_pkg::*;

	localparam int TAPS        = FILTER_ORDER + 1;
	localparam int POS_W       = $clog2(TAPS);
	localparam int RINGS       = BAND_COUNT + 2;
	localparam int HDEPTH      = RINGS * TAPS * 2;
	localparam int HADDR_W     = $clog2(HDEPTH);
	localparam int CDEPTH      = (BAND_COUNT + 1) * 2 * TAPS;
	localparam int CADDR_W     = $clog2(CDEPTH);
	localparam int SECOND_BASE = BAND_COUNT * 2 * TAPS;
	localparam int BAND_W      = (BAND_COUNT > 1) ? $clog2(BAND_COUNT) : 1;
	localparam int TERM_W      = $clog2(2 * FILTER_ORDER + 1);
	localparam int CLR_DEPTH   = (HDEPTH > CDEPTH) ? HDEPTH : CDEPTH;
	localparam int CLR_W       = $clog2(CLR_DEPTH + 1);
	// ring numbers inside the history RAM
	localparam int RING_IN     = 0;
	localparam int RING_FIRST  = 1;
	localparam int RING_BAND0  = 2;

	function automatic logic [HADDR_W-1:0] haddr(input int ring, input int p, input int c);
		return HADDR_W'((ring * TAPS + p) * 2 + c);
	endfunction

	state_t state_q, state_d;

	item_t                     item;
	logic                      in_take;
	logic [2:0]                casc_q;
	logic [POS_W-1:0]          pos_q;
	logic signed [23:0]        right_q, left_q;
	logic [BAND_W-1:0]         band_q;
	logic                      ch_q;
	logic                      sec2_q;
	logic [TERM_W-1:0]         term_q;
	logic [CLR_W-1:0]          clr_q;
	logic [GAIN_W-1:0]         gain_q [BAND_COUNT];
	logic                      valid_s1, valid_s2, den_s1, den_s2;
	logic signed [63:0]        prod_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [31:0]        y_q;
	logic signed [SUM_W-1:0]   sum_q [2];
	result_t                   out_q;
	logic                      out_valid_q;

	logic                      cascading;
	logic                      last_term;
	logic                      sec_done;
	logic                      drained;
	logic signed [31:0]        sat_y;

	logic                      h_we;
	logic [HADDR_W-1:0]        h_waddr, h_raddr;
	logic [31:0]               h_wdata, h_rdata;
	logic                      c_we;
	logic [CADDR_W-1:0]        c_waddr, c_raddr;
	logic [31:0]               c_wdata, c_rdata;
	logic signed [31:0]        mul_a, mul_b;

	assign item      = items.data;
	assign in_take   = items.valid && items.ready;
	assign cascading = (int'(casc_q) == int'(band_q));
	assign last_term = (int'(term_q) == 2 * FILTER_ORDER);
	assign drained   = !valid_s1 && !valid_s2;
	assign sec_done  = !cascading || sec2_q;

	// section result saturated to the 32-bit history range
	always_comb begin
		if (acc_q > $signed({{(ACC_W-31){1'b0}}, {31{1'b1}}}))
			sat_y = 32'sh7fffffff;
		else if (acc_q < $signed({{(ACC_W-31){1'b1}}, {31{1'b0}}}))
			sat_y = 32'sh80000000;
		else
			sat_y = acc_q[31:0];
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (int'(clr_q) == CLR_DEPTH - 1) state_d = ST_IDLE;
			ST_IDLE:  if (in_take && item.cmd == CMD_SAMPLE) state_d = ST_LOAD;
			ST_LOAD:  if (ch_q) state_d = ST_ISSUE;
			ST_ISSUE: if (last_term) state_d = ST_DRAIN;
			ST_DRAIN: if (drained) state_d = ST_WB;
			ST_WB:    state_d = sec_done ? ST_GMUL : ST_ISSUE;
			ST_GMUL:  state_d = ST_GACC;
			ST_GACC: begin
				if (ch_q && int'(band_q) == BAND_COUNT - 1)
					state_d = ST_DONE;
				else
					state_d = ST_ISSUE;
			end
			ST_DONE:  if (!out_valid_q || results.ready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer: RAM ports and multiplier operands
	always_comb begin
		int i;
		int idx;
		int xr;
		int yr;
		int ring;
		int cbase;
		h_we    = 1'b0;
		h_waddr = '0;
		h_wdata = '0;
		h_raddr = '0;
		c_we    = 1'b0;
		c_waddr = '0;
		c_wdata = '0;
		c_raddr = '0;
		mul_a   = $signed(h_rdata);
		mul_b   = $signed(c_rdata);
		i       = (int'(term_q) <= FILTER_ORDER) ? int'(term_q) : int'(term_q) - FILTER_ORDER;
		idx     = int'(pos_q) + TAPS - i;
		if (idx >= TAPS)
			idx = idx - TAPS;
		xr      = (cascading && sec2_q) ? RING_FIRST : RING_IN;
		yr      = (cascading && !sec2_q) ? RING_FIRST : RING_BAND0 + int'(band_q);
		ring    = (int'(term_q) <= FILTER_ORDER) ? xr : yr;
		cbase   = sec2_q ? SECOND_BASE : int'(band_q) * 2 * TAPS;
		case (state_q)
			ST_CLEAR: begin
				h_we    = int'(clr_q) < HDEPTH;
				h_waddr = HADDR_W'(clr_q);
				c_we    = int'(clr_q) < CDEPTH;
				c_waddr = CADDR_W'(clr_q);
			end
			ST_IDLE: begin
				if (in_take && item.cmd == CMD_COEF && int'(item.tap) <= FILTER_ORDER
				    && (item.section || int'(item.band) < BAND_COUNT)) begin
					c_we    = 1'b1;
					c_waddr = CADDR_W'((item.section ? SECOND_BASE : int'(item.band) * 2 * TAPS)
					          + int'(item.coef_kind) * TAPS + int'(item.tap));
					c_wdata = item.coef_value;
				end
			end
			ST_LOAD: begin
				h_we    = 1'b1;
				h_waddr = haddr(RING_IN, int'(pos_q), int'(ch_q));
				h_wdata = ch_q ? {left_q, 8'd0} : {right_q, 8'd0};
			end
			ST_ISSUE: begin
				h_raddr = haddr(ring, idx, int'(ch_q));
				c_raddr = CADDR_W'(cbase + ((int'(term_q) <= FILTER_ORDER) ? i : TAPS + i));
			end
			ST_WB: begin
				h_we    = 1'b1;
				h_waddr = haddr(sec_done ? RING_BAND0 + int'(band_q) : RING_FIRST,
				                int'(pos_q), int'(ch_q));
				h_wdata = sat_y;
			end
			ST_GMUL: begin
				mul_a = y_q;
				mul_b = $signed({{(32-GAIN_W){1'b0}}, gain_q[band_q]});
			end
			default: ;
		endcase
	end

	smeq_ram #(.WIDTH(32), .DEPTH(HDEPTH)) u_hist_ram (
		.clk   (clk),
		.we    (h_we),
		.waddr (h_waddr),
		.wdata (h_wdata),
		.raddr (h_raddr),
		.rdata (h_rdata)
	);

	smeq_ram #(.WIDTH(32), .DEPTH(CDEPTH)) u_coef_ram (
		.clk   (clk),
		.we    (c_we),
		.waddr (c_waddr),
		.wdata (c_wdata),
		.raddr (c_raddr),
		.rdata (c_rdata)
	);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			casc_q      <= 3'(BAND_COUNT);
			pos_q       <= '0;
			band_q      <= '0;
			ch_q        <= 1'b0;
			sec2_q      <= 1'b0;
			term_q      <= '0;
			clr_q       <= '0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
			for (int b = 0; b < BAND_COUNT; b++)
				gain_q[b] <= UNITY_GAIN;
		end else begin
			state_q  <= state_d;
			valid_s1 <= (state_q == ST_ISSUE);
			valid_s2 <= valid_s1;
			if (cfg_we)
				casc_q <= cfg_wdata;
			// output register: loaded when free or drained this cycle
			if (state_q == ST_DONE && (!out_valid_q || results.ready))
				out_valid_q <= 1'b1;
			else if (results.valid && results.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_CLEAR: clr_q <= clr_q + 1'b1;
				ST_IDLE: begin
					if (in_take && item.cmd == CMD_SAMPLE) begin
						pos_q <= (int'(pos_q) >= FILTER_ORDER) ? '0 : pos_q + 1'b1;
						ch_q  <= 1'b0;
					end
					if (in_take && item.cmd == CMD_GAIN && int'(item.band) < BAND_COUNT) begin
						if (item.gain_tenths_db > 8'sd120)
							gain_q[BAND_W'(item.band)] <= GAIN_TAB[2 * GAIN_MAX];
						else if (item.gain_tenths_db < -8'sd120)
							gain_q[BAND_W'(item.band)] <= GAIN_TAB[0];
						else
							gain_q[BAND_W'(item.band)] <=
								GAIN_TAB[8'(int'(item.gain_tenths_db) + GAIN_MAX)];
					end
				end
				ST_LOAD: begin
					ch_q   <= ~ch_q;
					band_q <= '0;
					sec2_q <= 1'b0;
					term_q <= '0;
				end
				ST_ISSUE: term_q <= last_term ? '0 : term_q + 1'b1;
				ST_WB:    if (!sec_done) sec2_q <= 1'b1;
				ST_GACC: begin
					sec2_q <= 1'b0;
					ch_q   <= ~ch_q;
					if (ch_q)
						band_q <= (int'(band_q) == BAND_COUNT - 1) ? '0 : band_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		den_s1 <= (int'(term_q) > FILTER_ORDER);
		den_s2 <= den_s1;
		if (state_q == ST_IDLE && in_take && item.cmd == CMD_SAMPLE) begin
			right_q <= item.right_sample;
			left_q  <= item.left_sample;
		end
		// accumulate one floored tap product per beat
		if (state_q == ST_LOAD || state_q == ST_WB)
			acc_q <= '0;
		else if (valid_s2) begin
			if (den_s2)
				acc_q <= acc_q - ACC_W'(prod_q >>> 29);
			else
				acc_q <= acc_q + ACC_W'(prod_q >>> 29);
		end
		if (state_q == ST_WB)
			y_q <= sat_y;
		if (state_q == ST_LOAD) begin
			sum_q[0] <= '0;
			sum_q[1] <= '0;
		end else if (state_q == ST_GACC)
			sum_q[ch_q] <= sum_q[ch_q] + SUM_W'(prod_q);
		// floor, saturate and present the stereo result
		if (state_q == ST_DONE && (!out_valid_q || results.ready)) begin
			for (int c = 0; c < 2; c++) begin
				logic signed [SUM_W-25:0] o;
				logic signed [23:0]       s;
				o = (SUM_W-24)'(sum_q[c] >>> 24);
				if (o > $signed((SUM_W-24)'(8388607)))
					s = 24'sh7fffff;
				else if (o < -$signed((SUM_W-24)'(8388608)))
					s = 24'sh800000;
				else
					s = o[23:0];
				if (c == 0)
					out_q.right_out <= s;
				else
					out_q.left_out <= s;
			end
		end
	end

	assign items.ready   = (state_q == ST_IDLE);
	assign results.valid = out_valid_q;
	assign results.data  = out_q;

endmodule
